// ----- design/plng_pkg.sv -----
// Shared types, widths and helper functions for the lattice neighbor generator.
package plng_pkg;

  // Field widths
  localparam int MAX_DIM   = 4;
  localparam int SITE_W    = 16;
  localparam int EDGE_W    = SITE_W + 2;
  localparam int AXIS_W    = $clog2(MAX_DIM);
  localparam int COORD_W   = 8;
  localparam int SIZE_W    = 9;
  localparam int DIM_W     = 3;
  localparam int MAX_SIZE  = 1 << COORD_W;
  localparam int MIN_SIZE  = 2;
  localparam int RES_W     = AXIS_W + 1;

  // Reciprocal of the linear size: ceil(2^RECIP_SHIFT / size) is exact for
  // every site index below 2^SITE_W and every size up to 2^COORD_W.
  localparam int RECIP_SHIFT = SITE_W + COORD_W;
  localparam int RECIP_W     = RECIP_SHIFT;
  localparam int DIV_W       = RECIP_SHIFT + 1;
  localparam int DIV_CNT_W   = $clog2(DIV_W);
  localparam int PROD_W      = SITE_W + RECIP_W;

  // Queue of classified items between front and back
  localparam int QDEPTH = 2;

  // Register map
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_DIMENSION   = 1'b0;
  localparam logic REG_LINEAR_SIZE = 1'b1;

  localparam logic [DIM_W-1:0]  DIM_RESET  = DIM_W'(2);
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

  // Setup sequencer states
  typedef enum logic [2:0] {
    SU_LOAD,
    SU_DIV,
    SU_POW,
    SU_SCALE,
    SU_IDLE
  } su_state_t;

  // Front engine states
  typedef enum logic [1:0] {
    FE_IDLE,
    FE_MUL,
    FE_DIGIT,
    FE_HOLD
  } fe_state_t;

  // Derived lattice constants, valid while busy is low
  typedef struct packed {
    logic                             busy;
    logic [DIM_W-1:0]                 dim;
    logic [SIZE_W-1:0]                size;
    logic [COORD_W-1:0]               size_m1;
    logic [RECIP_W-1:0]               recip;
    logic [MAX_DIM-1:0][EDGE_W-1:0]   stride;    // size^axis
    logic [MAX_DIM-1:0][EDGE_W-1:0]   span;      // (size-1)*size^axis
    logic [MAX_DIM-1:0][EDGE_W-1:0]   dstride;   // dim*stride
    logic [MAX_DIM-1:0][EDGE_W-1:0]   dspan;     // dim*span
  } plng_cfg_t;

  // Classified site from the front
  typedef struct packed {
    logic [SITE_W-1:0]                site;
    logic [EDGE_W-1:0]                dsite;
    logic [MAX_DIM-1:0][COORD_W-1:0]  coord;
    logic                             oor;
  } plng_item_t;

  // One result item
  typedef struct packed {
    logic [SITE_W-1:0]  neighbor_site;
    logic [EDGE_W-1:0]  edge_index;
    logic [AXIS_W-1:0]  axis;
    logic               toward_minus;
    logic [COORD_W-1:0] coordinate;
    logic               out_of_range;
    logic               last;
  } plng_result_t;

  // Clamp the dimension register to 1..MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    r = d;
    if (d == DIM_W'(0)) r = DIM_W'(1);
    else if (d > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    return r;
  endfunction

  // Clamp the linear size register to MIN_SIZE..MAX_SIZE
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] l);
    logic [SIZE_W-1:0] r;
    r = l;
    if (l < SIZE_W'(MIN_SIZE)) r = SIZE_W'(MIN_SIZE);
    else if (l > SIZE_W'(MAX_SIZE)) r = SIZE_W'(MAX_SIZE);
    return r;
  endfunction

endpackage

// ----- design/plng_setup.sv -----
// Setup sequencer: reciprocal divider and per-axis stride tables.
module plng_setup (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [plng_pkg::DIM_W-1:0]  dimension,
  input  logic [plng_pkg::SIZE_W-1:0] linear_size,
  output plng_pkg::plng_cfg_t         cfg
);
  import plng_pkg::*;

  su_state_t state, state_next;

  logic [DIM_W-1:0]             dim;
  logic [SIZE_W-1:0]            size;
  logic [DIV_W-1:0]             num;
  logic [SIZE_W:0]              rem;
  logic [DIV_W-1:0]             quot;
  logic [DIV_CNT_W-1:0]         cnt;
  logic [AXIS_W-1:0]            step;
  logic [MAX_DIM-1:0][EDGE_W-1:0] stride, span, dstride, dspan;

  logic [SIZE_W:0]  rem_sh;
  logic             rem_ge;
  logic [EDGE_W-1:0] pow_prod;
  logic             step_last;

  assign dim  = clamp_dim(dimension);
  assign size = clamp_size(linear_size);

  assign rem_sh    = {rem[SIZE_W-1:0], num[DIV_W-1]};
  assign rem_ge    = rem_sh >= {1'b0, size};
  assign pow_prod  = EDGE_W'(stride[step] * size);
  assign step_last = step == AXIS_W'(MAX_DIM - 1);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      SU_LOAD:  state_next = SU_DIV;
      SU_DIV:   if (cnt == '0) state_next = SU_POW;
      SU_POW:   if (step_last) state_next = SU_SCALE;
      SU_SCALE: if (step_last) state_next = SU_IDLE;
      SU_IDLE:  state_next = SU_IDLE;
      default:  state_next = SU_LOAD;
    endcase
    if (start) state_next = SU_LOAD;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= SU_LOAD;
    else     state <= state_next;
  end

  // Divider, power and scale datapath
  always_ff @(posedge clk) begin
    case (state)
      SU_LOAD: begin
        num       <= (DIV_W'(1) << RECIP_SHIFT) + DIV_W'(size) - DIV_W'(1);
        rem       <= '0;
        quot      <= '0;
        cnt       <= DIV_CNT_W'(DIV_W - 1);
        step      <= '0;
        stride[0] <= EDGE_W'(1);
      end
      SU_DIV: begin
        rem  <= rem_ge ? rem_sh - {1'b0, size} : rem_sh;
        quot <= {quot[DIV_W-2:0], rem_ge};
        num  <= {num[DIV_W-2:0], 1'b0};
        cnt  <= cnt - DIV_CNT_W'(1);
      end
      SU_POW: begin
        if (!step_last) stride[step + AXIS_W'(1)] <= pow_prod;
        span[step] <= pow_prod - stride[step];
        step       <= step_last ? '0 : step + AXIS_W'(1);
      end
      SU_SCALE: begin
        dstride[step] <= EDGE_W'(dim * stride[step]);
        dspan[step]   <= EDGE_W'(dim * span[step]);
        step          <= step + AXIS_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Outputs
  always_comb begin
    cfg.busy    = state != SU_IDLE;
    cfg.dim     = dim;
    cfg.size    = size;
    cfg.size_m1 = COORD_W'(size - SIZE_W'(1));
    cfg.recip   = quot[RECIP_W-1:0];
    cfg.stride  = stride;
    cfg.span    = span;
    cfg.dstride = dstride;
    cfg.dspan   = dspan;
  end

endmodule

// ----- design/plng_front.sv -----
// Front part: input buffer and digit extraction of the site index.
module plng_front (
  input  logic                        clk,
  input  logic                        rst,
  input  plng_pkg::plng_cfg_t         cfg,
  input  logic                        push,
  input  logic [plng_pkg::SITE_W-1:0] site_index,
  output logic                        full,
  output logic                        q_push,
  output plng_pkg::plng_item_t        q_item,
  input  logic                        q_full
);
  import plng_pkg::*;

  fe_state_t state, state_next;

  logic                buf_valid;
  logic [SITE_W-1:0]   buf_site;
  logic [SITE_W-1:0]   site;
  logic [SITE_W-1:0]   rest;
  logic [AXIS_W-1:0]   ax;
  logic [PROD_W-1:0]   prod;
  logic [MAX_DIM-1:0][COORD_W-1:0] coord;
  logic [EDGE_W-1:0]   dsite;
  logic                oor;

  logic                accept;
  logic                load;
  logic                last_axis;
  logic [SITE_W-1:0]   quo;
  logic [COORD_W-1:0]  ql;
  logic [COORD_W-1:0]  digit;

  // Digit = rest - floor(rest / size) * size, low bits suffice
  assign quo       = prod[PROD_W-1 -: SITE_W];
  assign ql        = COORD_W'(quo[COORD_W-1:0] * cfg.size[COORD_W-1:0]);
  assign digit     = rest[COORD_W-1:0] - ql;
  assign last_axis = (DIM_W'(ax) + DIM_W'(1)) == cfg.dim;

  assign full   = buf_valid | cfg.busy;
  assign accept = push & ~full;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      FE_IDLE:  if (buf_valid && !cfg.busy) state_next = FE_MUL;
      FE_MUL:   state_next = FE_DIGIT;
      FE_DIGIT: state_next = last_axis ? FE_HOLD : FE_MUL;
      FE_HOLD:  if (!q_full) state_next = buf_valid ? FE_MUL : FE_IDLE;
      default:  state_next = FE_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    load   = 1'b0;
    q_push = 1'b0;
    case (state)
      FE_IDLE: load = buf_valid & ~cfg.busy;
      FE_HOLD: begin
        q_push = ~q_full;
        load   = ~q_full & buf_valid;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FE_IDLE;
      buf_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept)    buf_valid <= 1'b1;
      else if (load) buf_valid <= 1'b0;
    end
  end

  // Hold the waiting site
  always_ff @(posedge clk) begin
    if (accept) buf_site <= site_index;
  end

  // Extract one coordinate per pass through the multiply and digit states
  always_ff @(posedge clk) begin
    if (load) begin
      site  <= buf_site;
      rest  <= buf_site;
      ax    <= '0;
      dsite <= EDGE_W'(cfg.dim * buf_site);
    end else if (state == FE_MUL) begin
      prod <= rest * cfg.recip;
    end else if (state == FE_DIGIT) begin
      coord[ax] <= digit;
      rest      <= quo;
      ax        <= ax + AXIS_W'(1);
      if (last_axis) oor <= quo != '0;
    end
  end

  assign q_item.site  = site;
  assign q_item.dsite = dsite;
  assign q_item.coord = coord;
  assign q_item.oor   = oor;

endmodule

// ----- design/plng_fifo.sv -----
// Short queue of classified items between front and back.
module plng_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr,
  input  plng_pkg::plng_item_t  wr_item,
  output logic                  q_full,
  input  logic                  rd,
  output plng_pkg::plng_item_t  rd_item,
  output logic                  q_empty
);
  import plng_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  plng_item_t       mem [QDEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign q_full  = count == CNT_W'(QDEPTH);
  assign q_empty = count == '0;
  assign do_wr   = wr & ~q_full;
  assign do_rd   = rd & ~q_empty;
  assign rd_item = mem[rd_ptr];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (do_rd) rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (do_wr && !do_rd)      count <= count + CNT_W'(1);
      else if (do_rd && !do_wr) count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_item;
  end

endmodule

// ----- design/plng_back.sv -----
// Back part: walks the axes of one item, registering one result per cycle while results are popped.
module plng_back (
  input  logic                   clk,
  input  logic                   rst,
  input  plng_pkg::plng_cfg_t    cfg,
  input  plng_pkg::plng_item_t   item,
  input  logic                   q_empty,
  output logic                   q_pop,
  input  logic                   pop,
  output logic                   empty,
  output plng_pkg::plng_result_t result
);
  import plng_pkg::*;

  logic [RES_W-1:0]   k;
  logic               out_valid;
  plng_result_t       res_next;

  logic [AXIS_W-1:0]  ax;
  logic               minus;
  logic [COORD_W-1:0] c;
  logic [EDGE_W-1:0]  site_x;
  logic [EDGE_W-1:0]  nb;
  logic [EDGE_W-1:0]  edge_off;
  logic               wrap;
  logic               load_out;

  assign ax     = k[RES_W-1:1];
  assign minus  = k[0];
  assign c      = item.coord[ax];
  assign site_x = EDGE_W'(item.site);
  assign wrap   = minus ? (c == '0) : (c == cfg.size_m1);

  // Neighbor and edge offset for this direction
  always_comb begin
    if (!minus) begin
      nb       = wrap ? site_x - cfg.span[ax] : site_x + cfg.stride[ax];
      edge_off = '0;
    end else begin
      nb       = wrap ? site_x + cfg.span[ax] : site_x - cfg.stride[ax];
      edge_off = wrap ? cfg.dspan[ax] : EDGE_W'(0) - cfg.dstride[ax];
    end
  end

  // Assemble the next result
  always_comb begin
    if (item.oor) begin
      res_next = '0;
      res_next.out_of_range = 1'b1;
      res_next.last         = 1'b1;
    end else begin
      res_next.neighbor_site = nb[SITE_W-1:0];
      res_next.edge_index    = item.dsite + edge_off + EDGE_W'(ax);
      res_next.axis          = ax;
      res_next.toward_minus  = minus;
      res_next.coordinate    = c;
      res_next.out_of_range  = 1'b0;
      res_next.last          = minus & ((DIM_W'(ax) + DIM_W'(1)) == cfg.dim);
    end
  end

  assign load_out = ~q_empty & (~out_valid | pop);
  assign q_pop    = load_out & res_next.last;
  assign empty    = ~out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      k         <= '0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
        k         <= res_next.last ? '0 : k + RES_W'(1);
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (load_out) result <= res_next;
  end

endmodule

// ----- design/periodic_lattice_neighbor_generator_unit.sv -----
// Top level of the periodic lattice neighbor generator.
// Each site index pushed in yields 2*dimension results (plus then minus
// neighbor per axis, axis 0 first), or a single out_of_range result when the
// index is not below linear_size^dimension. The front extracts one coordinate
// per pass through a multiply state and a digit state, using a reciprocal
// multiplier, then hands the item to the queue in a hold state, whether or not
// it is in range; the back emits one result per cycle while results are popped.
// The front is therefore the slower side and sets the sustained item rate.
// A two-entry queue and a one-item input buffer let both sides stall apart.
// After reset and after every register write a setup sequence runs with full
// held high: a 25-step reciprocal division, then the per-axis stride tables.
module periodic_lattice_neighbor_generator_unit (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [plng_pkg::ADDR_W-1:0]  paddr,
  input  logic [plng_pkg::DATA_W-1:0]  pwdata,
  output logic [plng_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  // input items
  input  logic                         push,
  output logic                         full,
  input  logic [plng_pkg::SITE_W-1:0]  site_index,
  // result items
  output logic                         empty,
  input  logic                         pop,
  output logic [plng_pkg::SITE_W-1:0]  neighbor_site,
  output logic [plng_pkg::EDGE_W-1:0]  edge_index,
  output logic [plng_pkg::AXIS_W-1:0]  axis,
  output logic                         toward_minus,
  output logic [plng_pkg::COORD_W-1:0] coordinate,
  output logic                         out_of_range,
  output logic                         last
);
  import plng_pkg::*;

  logic [DIM_W-1:0]  dimension;
  logic [SIZE_W-1:0] linear_size;
  logic              cfg_write;

  plng_cfg_t    cfg;
  plng_item_t   f_item, b_item;
  plng_result_t result;
  logic         q_push, q_full, q_pop, q_empty;

  // Register port
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension   <= DIM_RESET;
      linear_size <= SIZE_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_DIMENSION:   dimension   <= pwdata[DIM_W-1:0];
        REG_LINEAR_SIZE: linear_size <= pwdata[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DIMENSION:   prdata = DATA_W'(dimension);
      REG_LINEAR_SIZE: prdata = DATA_W'(linear_size);
      default:         prdata = '0;
    endcase
  end

  plng_setup u_setup (
    .clk         (clk),
    .rst         (rst),
    .start       (cfg_write),
    .dimension   (dimension),
    .linear_size (linear_size),
    .cfg         (cfg)
  );

  plng_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .push       (push),
    .site_index (site_index),
    .full       (full),
    .q_push     (q_push),
    .q_item     (f_item),
    .q_full     (q_full)
  );

  plng_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_item (f_item),
    .q_full  (q_full),
    .rd      (q_pop),
    .rd_item (b_item),
    .q_empty (q_empty)
  );

  plng_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .item    (b_item),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

  assign neighbor_site = result.neighbor_site;
  assign edge_index    = result.edge_index;
  assign axis          = result.axis;
  assign toward_minus  = result.toward_minus;
  assign coordinate    = result.coordinate;
  assign out_of_range  = result.out_of_range;
  assign last          = result.last;

endmodule

// ----- design/plng_checker.sv -----
// Port-level checks for the lattice neighbor generator, bound to the top level.
module plng_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic                         pready,
  input logic                         push,
  input logic                         full,
  input logic                         empty,
  input logic                         pop,
  input logic [plng_pkg::SITE_W-1:0]  neighbor_site,
  input logic [plng_pkg::EDGE_W-1:0]  edge_index,
  input logic [plng_pkg::AXIS_W-1:0]  axis,
  input logic                         toward_minus,
  input logic [plng_pkg::COORD_W-1:0] coordinate,
  input logic                         out_of_range,
  input logic                         last
);

  // A waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(neighbor_site) && $stable(edge_index)
                          && $stable(axis) && $stable(toward_minus)
                          && $stable(coordinate) && $stable(out_of_range)
                          && $stable(last)))
    else $error("waiting result changed before it was taken");

  // An out-of-range item gives a single cleared result
  a_oor: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_of_range) |-> (last && neighbor_site == '0 && edge_index == '0
                                  && axis == '0 && !toward_minus))
    else $error("out-of-range result is malformed");

  // A run ends on a minus neighbor
  a_plus_not_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && !out_of_range && !toward_minus) |-> !last)
    else $error("plus neighbor marked as last");

  // A register write starts setup, which blocks input
  a_cfg_full: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready) |=> full)
    else $error("input accepted during setup");

  // Reset leaves no result and runs setup
  a_reset: assert property (@(posedge clk) rst |=> (empty && full))
    else $error("reset state wrong");

  // A push while full sees full still high, which always holds
  a_push_ok: assert property (@(posedge clk) disable iff (rst)
    (push && full) |-> full)
    else $error("input handshake malformed");

endmodule

bind periodic_lattice_neighbor_generator_unit plng_checker u_plng_checker (.*);
